>>> design/pipw_pkg.sv
// ----------------------------------------------------------------------------
// pipw_pkg
// types and fixed widths shared by the winding-number point-in-polygon unit
// ----------------------------------------------------------------------------
package pipw_pkg;

  localparam int FIELD_W = 16;  // width of coordinate fields and registers
  localparam int OUT_W   = 13;  // width of the doubled winding number
  localparam int INDEX_W = 2;   // width of the configuration register index

  typedef enum logic [INDEX_W-1:0] {
    REG_REF_X = 2'd0,
    REG_REF_Y = 2'd1
  } reg_index_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vertex_x;
    logic signed [FIELD_W-1:0] vertex_y;
    logic                      last_vertex;
  } vertex_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] winding_halves;
    logic                    outside;
  } result_t;

endpackage

>>> design/point_in_polygon_winding_unit.sv
// ----------------------------------------------------------------------------
// point_in_polygon_winding_unit
// winding-number test of a query point against a streamed polygon
// ----------------------------------------------------------------------------
// a vertex transfer is held in the input register; when the edge stage fires on a
// closing vertex, its result loads into the result register, which raises
// result valid
// throughput: one vertex per cycle from the single edge stage; a closing
// vertex stalls only while an earlier result still waits for its transfer
// reset: clears the query point, polygon state, accumulator and valid flags
module point_in_polygon_winding_unit #(
  parameter int COORD_BITS = 16,
  parameter int ACC_BITS   = 12
) (
  input  logic                                clk,
  input  logic                                rst,

  // configuration writes
  input  logic                                cfg_en,
  input  logic [pipw_pkg::INDEX_W-1:0]        cfg_index,
  input  logic [pipw_pkg::FIELD_W-1:0]        cfg_data,

  // vertex stream
  input  logic                                vertex_valid,
  output logic                                vertex_ready,
  input  pipw_pkg::vertex_t                   vertex,

  // result stream
  output logic                                result_valid,
  input  logic                                result_ready,
  output pipw_pkg::result_t                   result
);

  // coordinates keep their low bits only, never more than the field width
  localparam int CW = (COORD_BITS < pipw_pkg::FIELD_W) ? COORD_BITS : pipw_pkg::FIELD_W;
  localparam int DW = CW + 1;          // coordinate differences
  localparam int MW = 2 * DW;          // one cross product term
  localparam int PW = MW + 1;          // difference of the two terms
  localparam int WB = (ACC_BITS > pipw_pkg::OUT_W) ? ACC_BITS : pipw_pkg::OUT_W;

  localparam int OUT_MAX_I = 2 ** (pipw_pkg::OUT_W - 1) - 1;
  localparam logic signed [WB-1:0] OUT_MAX = WB'(OUT_MAX_I);
  localparam logic signed [WB-1:0] OUT_MIN = WB'(-OUT_MAX_I - 1);

  // --------------------------------------------------------------------------
  // per-edge half-turn count
  // --------------------------------------------------------------------------
  function automatic logic signed [2:0] edge_halves(
    input logic signed [CW-1:0] px,
    input logic signed [CW-1:0] py,
    input logic signed [CW-1:0] qx,
    input logic signed [CW-1:0] qy,
    input logic signed [CW-1:0] rx,
    input logic signed [CW-1:0] ry
  );
    logic signed [DW-1:0] a, b, dqx, dry, drx, dqy;
    logic signed [MW-1:0] p1, p2;
    logic signed [PW-1:0] c;
    logic                 a_neg, a_pos, b_neg, b_pos, c_neg, c_pos, opp;
    logic signed [2:0]    r;
    a   = {py[CW-1], py} - {ry[CW-1], ry};
    b   = {qy[CW-1], qy} - {ry[CW-1], ry};
    dqx = {qx[CW-1], qx} - {px[CW-1], px};
    dry = {ry[CW-1], ry} - {py[CW-1], py};
    drx = {rx[CW-1], rx} - {px[CW-1], px};
    dqy = {qy[CW-1], qy} - {py[CW-1], py};
    p1  = MW'(dqx) * MW'(dry);
    p2  = MW'(drx) * MW'(dqy);
    c   = {p1[MW-1], p1} - {p2[MW-1], p2};
    a_neg = a[DW-1];
    a_pos = !a[DW-1] && (a != '0);
    b_neg = b[DW-1];
    b_pos = !b[DW-1] && (b != '0);
    c_neg = c[PW-1];
    c_pos = !c[PW-1] && (c != '0);
    opp   = (a_neg && b_pos) || (a_pos && b_neg);
    if (a == '0 && b == '0) begin
      r = 3'sd0;
    end else if (opp) begin
      if ((c_pos && a_neg) || (c_neg && a_pos)) begin
        r = a_neg ? 3'sd2 : -3'sd2;
      end else begin
        r = 3'sd0;
      end
    end else if (a == '0 && px > rx) begin
      r = b_pos ? 3'sd1 : -3'sd1;
    end else if (b == '0 && qx > rx) begin
      r = a_neg ? 3'sd1 : -3'sd1;
    end else begin
      r = 3'sd0;
    end
    return r;
  endfunction

  // saturating add of a half-turn count into the accumulator
  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] acc_in,
    input logic signed [2:0]          d
  );
    logic signed [ACC_BITS:0]   sum;
    logic signed [ACC_BITS-1:0] r;
    sum = {acc_in[ACC_BITS-1], acc_in} + {{(ACC_BITS - 2){d[2]}}, d};
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      r = sum[ACC_BITS] ? {1'b1, {(ACC_BITS - 1){1'b0}}} : {1'b0, {(ACC_BITS - 1){1'b1}}};
    end else begin
      r = sum[ACC_BITS-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]       ref_x, ref_y;
  logic signed [CW-1:0]       first_x, first_y, prev_x, prev_y;
  logic                       have_first;
  logic signed [ACC_BITS-1:0] winding_acc;

  logic                       s0_valid;      // input register holds a vertex
  pipw_pkg::vertex_t          s0_item;

  // --------------------------------------------------------------------------
  // edge stage
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]       vx, vy, close_x, close_y;
  logic signed [2:0]          d_open, d_close;
  logic signed [ACC_BITS-1:0] acc_open, acc_close;
  logic signed [WB-1:0]       acc_wide, acc_clamped;
  logic                       fire;          // edge stage consumes the held vertex
  pipw_pkg::result_t          result_next;

  assign vx = s0_item.vertex_x[CW-1:0];
  assign vy = s0_item.vertex_y[CW-1:0];

  // on the first vertex of a polygon the closing edge runs back to itself
  assign close_x = have_first ? first_x : vx;
  assign close_y = have_first ? first_y : vy;

  assign d_open   = edge_halves(prev_x, prev_y, vx, vy, ref_x, ref_y);
  assign d_close  = edge_halves(vx, vy, close_x, close_y, ref_x, ref_y);
  assign acc_open  = have_first ? sat_add(winding_acc, d_open) : '0;
  assign acc_close = sat_add(acc_open, d_close);

  // clamp to the output range
  assign acc_wide = WB'(acc_close);
  always_comb begin
    if (acc_wide < OUT_MIN) begin
      acc_clamped = OUT_MIN;
    end else if (acc_wide > OUT_MAX) begin
      acc_clamped = OUT_MAX;
    end else begin
      acc_clamped = acc_wide;
    end
  end

  assign result_next.winding_halves = acc_clamped[pipw_pkg::OUT_W-1:0];
  assign result_next.outside        = (acc_close == '0);

  // a closing vertex needs the result register free, any other vertex moves on
  assign fire = s0_valid && (!s0_item.last_vertex || !result_valid || result_ready);
  assign vertex_ready = !s0_valid || fire;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x <= '0;
      ref_y <= '0;
    end else if (cfg_en) begin
      case (pipw_pkg::reg_index_t'(cfg_index))
        pipw_pkg::REG_REF_X: ref_x <= cfg_data[CW-1:0];
        pipw_pkg::REG_REF_Y: ref_y <= cfg_data[CW-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (vertex_ready) begin
      s0_valid <= vertex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (vertex_valid && vertex_ready) begin
      s0_item <= vertex;
    end
  end

  // --------------------------------------------------------------------------
  // polygon state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      first_x     <= '0;
      first_y     <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
      have_first  <= 1'b0;
      winding_acc <= '0;
    end else if (fire) begin
      if (!have_first) begin
        first_x <= vx;
        first_y <= vy;
      end
      prev_x <= vx;
      prev_y <= vy;
      if (s0_item.last_vertex) begin
        // polygon closed, wait for a fresh first vertex
        have_first  <= 1'b0;
        winding_acc <= '0;
      end else begin
        have_first  <= 1'b1;
        winding_acc <= acc_open;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && s0_item.last_vertex) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s0_item.last_vertex) begin
      result <= result_next;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // outside flag agrees with the clamped count
  a_outside_match: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.outside == (result.winding_halves == '0)))
    else $error("outside flag disagrees with winding count");

  // between polygons the accumulator sits at zero
  a_idle_acc_zero: assert property (@(posedge clk) disable iff (rst)
    !have_first |-> (winding_acc == '0))
    else $error("accumulator not cleared between polygons");

  // a closing vertex always lands a result
  a_close_gives_result: assert property (@(posedge clk) disable iff (rst)
    (fire && s0_item.last_vertex) |=> result_valid)
    else $error("closing vertex produced no result");

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the winding-number point-in-polygon unit
//
// streams polygons into the unit and predicts the doubled winding number and
// outside flag of each closed polygon; results are compared in order against
// the prediction, under several query points and idling patterns
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 16;
  localparam int ACC_BITS   = 12;

  // indexes with no register behind them, written to check they are ignored
  localparam logic [pipw_pkg::INDEX_W-1:0] IDX_SPARE_A = 2'd2;
  localparam logic [pipw_pkg::INDEX_W-1:0] IDX_SPARE_B = 2'd3;

  localparam longint COORD_MIN = -(longint'(1) <<< (pipw_pkg::FIELD_W - 1));
  localparam longint COORD_MAX = (longint'(1) <<< (pipw_pkg::FIELD_W - 1)) - 1;

  // random items per query point, per idling phase
  localparam int ITEMS_PER_SETTING = 44;

  // --------------------------------------------------------------------------
  // prediction and checking of closed polygons
  // --------------------------------------------------------------------------
  class winding_scoreboard;
    longint  query_x = 0;
    longint  query_y = 0;
    longint  start_x = 0;
    longint  start_y = 0;
    longint  tail_x  = 0;
    longint  tail_y  = 0;
    bit      open_polygon = 1'b0;
    longint  turn_count = 0;     // half turns, saturated to the accumulator range
    pipw_pkg::result_t pending_windings[$];
    int      n_mismatches = 0;

    function void set_register(logic [pipw_pkg::INDEX_W-1:0] idx,
                               logic [pipw_pkg::FIELD_W-1:0] data);
      case (pipw_pkg::reg_index_t'(idx))
        pipw_pkg::REG_REF_X: query_x = longint'($signed(data));
        pipw_pkg::REG_REF_Y: query_y = longint'($signed(data));
        default: ;
      endcase
    endfunction

    // signed half turns that one edge p -> q adds around the query point
    function int edge_half_turns(longint px, longint py, longint qx, longint qy);
      longint dy_from, dy_to, side;
      dy_from = py - query_y;
      dy_to   = qy - query_y;
      side    = (qx - px) * (query_y - py) - (query_x - px) * (qy - py);
      if (dy_from == 0 && dy_to == 0) return 0;
      if ((dy_from < 0 && dy_to > 0) || (dy_from > 0 && dy_to < 0)) begin
        if ((side > 0 && dy_from < 0) || (side < 0 && dy_from > 0))
          return (dy_from < 0) ? 2 : -2;
        return 0;
      end
      if (dy_from == 0 && px > query_x) return (dy_to > 0) ? 1 : -1;
      if (dy_to == 0 && qx > query_x) return (dy_from < 0) ? 1 : -1;
      return 0;
    endfunction

    function void add_half_turns(int d);
      longint hi, lo;
      hi = (longint'(1) <<< (ACC_BITS - 1)) - 1;
      lo = -hi - 1;
      turn_count += d;
      if (turn_count > hi) turn_count = hi;
      if (turn_count < lo) turn_count = lo;
    endfunction

    function void take_vertex(pipw_pkg::vertex_t v);
      longint  vx, vy, w, w_hi, w_lo;
      pipw_pkg::result_t r;
      vx = v.vertex_x;
      vy = v.vertex_y;
      if (!open_polygon) begin
        start_x      = vx;
        start_y      = vy;
        open_polygon = 1'b1;
        turn_count   = 0;
      end else begin
        add_half_turns(edge_half_turns(tail_x, tail_y, vx, vy));
      end
      tail_x = vx;
      tail_y = vy;
      if (v.last_vertex) begin
        add_half_turns(edge_half_turns(tail_x, tail_y, start_x, start_y));
        w_hi = (longint'(1) <<< (pipw_pkg::OUT_W - 1)) - 1;
        w_lo = -w_hi - 1;
        w = turn_count;
        if (w > w_hi) w = w_hi;
        if (w < w_lo) w = w_lo;
        r.winding_halves = w[pipw_pkg::OUT_W-1:0];
        r.outside        = (turn_count == 0);
        pending_windings = {pending_windings, r};
        open_polygon = 1'b0;
      end
    endfunction

    function void flag(string what);
      n_mismatches++;
      if (n_mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void check_result(pipw_pkg::result_t got);
      pipw_pkg::result_t want;
      if (pending_windings.size() == 0) begin
        flag($sformatf("result %0d/%0b with no polygon closed",
                       got.winding_halves, got.outside));
        return;
      end
      want = pending_windings.pop_front();
      if (got.winding_halves !== want.winding_halves)
        flag($sformatf("winding_halves expected %0d got %0d",
                       want.winding_halves, got.winding_halves));
      if (got.outside !== want.outside)
        flag($sformatf("outside expected %0b got %0b", want.outside, got.outside));
    endfunction

    function int pending();
      return pending_windings.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the unit
  // --------------------------------------------------------------------------
  logic                           clk          = 1'b0;
  logic                           rst          = 1'b1;
  logic                           cfg_en       = 1'b0;
  logic [pipw_pkg::INDEX_W-1:0]   cfg_index    = pipw_pkg::REG_REF_X;
  logic [pipw_pkg::FIELD_W-1:0]   cfg_data     = '0;
  logic                           vertex_valid = 1'b0;
  logic                           vertex_ready;
  pipw_pkg::vertex_t              vertex       = '0;
  logic                           result_valid;
  logic                           result_ready = 1'b0;
  pipw_pkg::result_t              result;

  winding_scoreboard sb = new();

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // query point as last written, used to aim the polygons
  longint cur_qx = 0;
  longint cur_qy = 0;

  int n_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  point_in_polygon_winding_unit #(
    .COORD_BITS (COORD_BITS),
    .ACC_BITS   (ACC_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_en       (cfg_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // result side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // observe every register write and every transfer on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_en) sb.set_register(cfg_index, cfg_data);
      if (vertex_valid && vertex_ready) sb.take_vertex(vertex);
      if (result_valid && result_ready) sb.check_result(result);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic int rnd(int lo, int hi);
    return int'($urandom_range(hi - lo)) + lo;
  endfunction

  // clamp into the coordinate range so aimed points near the edges stay legal
  function automatic logic signed [pipw_pkg::FIELD_W-1:0] clip(longint v);
    if (v < COORD_MIN) return COORD_MIN[pipw_pkg::FIELD_W-1:0];
    if (v > COORD_MAX) return COORD_MAX[pipw_pkg::FIELD_W-1:0];
    return v[pipw_pkg::FIELD_W-1:0];
  endfunction

  function automatic pipw_pkg::vertex_t make_vertex(longint x, longint y, bit last);
    pipw_pkg::vertex_t v;
    v.vertex_x    = clip(x);
    v.vertex_y    = clip(y);
    v.last_vertex = last;
    return v;
  endfunction

  // coordinate biased towards the query point, its line and the range ends
  function automatic longint pick_coord(longint centre);
    int mode;
    mode = $urandom_range(99);
    if (mode < 35) return centre + rnd(-8, 8);
    if (mode < 50) return centre;
    if (mode < 80) return longint'($signed(16'($urandom)));
    case ($urandom_range(6))
      0: return COORD_MIN;
      1: return COORD_MIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return COORD_MAX - 1;
      default: return COORD_MAX;
    endcase
  endfunction

  // one transfer; valid stays up straight into the next item unless we idle
  task automatic send_vertex(input pipw_pkg::vertex_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      vertex_valid <= 1'b0;
      @(posedge clk);
    end
    vertex_valid <= 1'b1;
    vertex       <= v;
    @(posedge clk);
    while (!vertex_ready) @(posedge clk);
    n_sent++;
  endtask

  // hold the sender until every closed polygon has come back, then let the
  // pipeline settle; sampled off the falling edge so the observer has run
  task automatic wait_drained();
    vertex_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  // both registers, then a write to an unused index that must change nothing
  task automatic write_query_point(input longint qx, input longint qy);
    cfg_en    <= 1'b1;
    cfg_index <= pipw_pkg::REG_REF_X;
    cfg_data  <= clip(qx);
    @(posedge clk);
    cfg_index <= pipw_pkg::REG_REF_Y;
    cfg_data  <= clip(qy);
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? IDX_SPARE_A : IDX_SPARE_B;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_en    <= 1'b0;
    cur_qx = clip(qx);
    cur_qy = clip(qy);
  endtask

  // polygon of triangular loops round the query point; each loop crosses the
  // ray on the right once (sense given by dir) and its line again on the left
  task automatic send_loops(input int n_turns, input int dir, input int flip_pct);
    int s;
    for (int t = 0; t < n_turns; t++) begin
      s = ($urandom_range(99) < flip_pct) ? -dir : dir;
      send_vertex(make_vertex(cur_qx + rnd(1, 1000), cur_qy - s * rnd(500, 1000), 1'b0));
      send_vertex(make_vertex(cur_qx + rnd(1, 1000), cur_qy + s * rnd(1, 1000), 1'b0));
      send_vertex(make_vertex(cur_qx - rnd(3000, 4000), cur_qy + s * rnd(1, 50),
                              t == n_turns - 1));
    end
  endtask

  task automatic send_random_polygon();
    int kind, n;
    kind = $urandom_range(99);
    if (kind < 30) begin
      send_loops(rnd(1, 6), $urandom_range(1) ? 1 : -1, 30);
    end else begin
      if (kind < 45)      n = rnd(1, 2);
      else if (kind < 95) n = rnd(3, 8);
      else                n = rnd(9, 20);
      for (int i = 0; i < n; i++)
        send_vertex(make_vertex(pick_coord(cur_qx), pick_coord(cur_qy), i == n - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int     first_item;
    longint qx, qy;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed polygons against the query point left at its reset value
    send_vertex(make_vertex(0, 0, 1'b1));                    // lone vertex on the point
    send_vertex(make_vertex(COORD_MIN, COORD_MAX, 1'b1));    // lone vertex at the corner
    // square counter-clockwise, then clockwise
    send_vertex(make_vertex(10, -10, 1'b0));
    send_vertex(make_vertex(10, 10, 1'b0));
    send_vertex(make_vertex(-10, 10, 1'b0));
    send_vertex(make_vertex(-10, -10, 1'b1));
    send_vertex(make_vertex(-10, -10, 1'b0));
    send_vertex(make_vertex(-10, 10, 1'b0));
    send_vertex(make_vertex(10, 10, 1'b0));
    send_vertex(make_vertex(10, -10, 1'b1));
    // diamond with corners on the ray and the vertical axis: half-turn cases
    send_vertex(make_vertex(10, 0, 1'b0));
    send_vertex(make_vertex(0, 10, 1'b0));
    send_vertex(make_vertex(-10, 0, 1'b0));
    send_vertex(make_vertex(0, -10, 1'b1));
    // edge lying along the ray, both directions
    send_vertex(make_vertex(5, 0, 1'b0));
    send_vertex(make_vertex(9, 0, 1'b1));
    // point sitting on a crossing edge
    send_vertex(make_vertex(0, -5, 1'b0));
    send_vertex(make_vertex(0, 5, 1'b0));
    send_vertex(make_vertex(-5, 0, 1'b1));
    // triangle spanning the full range
    send_vertex(make_vertex(COORD_MAX, COORD_MIN, 1'b0));
    send_vertex(make_vertex(COORD_MAX, COORD_MAX, 1'b0));
    send_vertex(make_vertex(COORD_MIN, 0, 1'b1));
    // diagonal through the point, collinear crossing
    send_vertex(make_vertex(COORD_MIN, COORD_MIN, 1'b0));
    send_vertex(make_vertex(COORD_MAX, COORD_MAX, 1'b1));
    wait_drained();

    // many-turn polygons in both senses, the odd loop turned back
    write_query_point(rnd(-20000, 20000), rnd(-20000, 20000));
    send_loops(40, 1, 1);
    send_loops(40, -1, 1);
    wait_drained();

    // random polygons: four idling patterns, each over six query points
    for (int phase = 0; phase < 4; phase++) begin
      for (int s = 0; s < 6; s++) begin
        case (s)
          0:       begin qx = COORD_MIN; qy = COORD_MIN; end
          1:       begin qx = COORD_MAX; qy = COORD_MAX; end
          2:       begin qx = COORD_MIN; qy = COORD_MAX; end
          3:       begin qx = COORD_MAX; qy = COORD_MIN; end
          default: begin qx = rnd(-32768, 32767); qy = rnd(-32768, 32767); end
        endcase
        wait_drained();
        write_query_point(qx, qy);
        case (phase)
          0:       begin send_idle_pct = 0;  stall_pct = 0;  end
          1:       begin send_idle_pct = 47; stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  stall_pct = 47; end
          default: begin send_idle_pct = 14; stall_pct = 14; end
        endcase
        first_item = n_sent;
        while (n_sent - first_item < ITEMS_PER_SETTING) begin
          // now and then let everything come back before the next polygon
          if ($urandom_range(99) < 6) wait_drained();
          send_random_polygon();
        end
      end
    end

    wait_drained();
    if (sb.n_mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
